// ===== rtl/fnhp_pkg.sv =====
// Shared constants, profile table and gradient sign table for the fractal noise height profile.
package fnhp_pkg;

  // Port and field widths
  localparam int COL_W      = 24;
  localparam int ROW_W      = 12;
  localparam int HEIGHT_W   = 12;
  localparam int PROF_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int MAX_OCTAVES_DEF = 6;

  // Internal datapath widths
  localparam int SCALE_W = 32;  // per-octave scale, Q.32
  localparam int LAC_W   = 18;  // lacunarity, Q.16
  localparam int PERS_W  = 16;  // persistence, Q0.16
  localparam int AMP_W   = 17;  // octave weight, Q.16, up to 1.0
  localparam int XF_W    = 16;  // cell fraction
  localparam int FADE_W  = 17;  // fade curve value
  localparam int NOISE_W = 18;  // signed noise, Q1.16
  localparam int SUM_W   = 36;  // weighted sum, Q.32 signed
  localparam int TOT_W   = 19;  // total weight, Q.16
  localparam int QUO_W   = 17;  // magnitude of normalised noise
  localparam int OCT_F_W = 3;
  localparam int PCT_W   = 7;
  localparam int BAND_W  = 23;  // top*2^16 + t*span
  localparam int V_W     = 19;  // (h*band) >> 16
  localparam int RCP_W   = 20;

  localparam logic [AMP_W-1:0] ONE_Q16 = 17'h10000;
  localparam int HALF_Q16 = 32768;

  // Division by 100 through a reciprocal, exact for values below 2^19
  localparam logic [RCP_W-1:0] RECIP_100   = 20'd671089;
  localparam int               RECIP_SHIFT = 26;

  // Profile codes
  localparam logic [PROF_W-1:0] PROF_NORMAL    = 2'd0;
  localparam logic [PROF_W-1:0] PROF_AMPLIFIED = 2'd1;
  localparam logic [PROF_W-1:0] PROF_FLAT      = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;

  localparam logic [PROF_W-1:0]   PROFILE_RST = PROF_NORMAL;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = 12'd480;

  // Gradient sign table
  localparam int GRAD_DEPTH = 256;
  localparam int GRAD_AW    = $clog2(GRAD_DEPTH);
  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_INC  = 32'd1013904223;
  localparam logic [31:0] LCG_SEED = 32'd42;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [LAC_W-1:0]   lac;
    logic [PERS_W-1:0]  pers;
    logic [OCT_F_W-1:0] oct;
    logic [PCT_W-1:0]   top;
    logic [PCT_W-1:0]   span;
  } prof_t;

  // Terrain profiles; the unused code falls back to normal
  function automatic prof_t prof_get(input logic [PROF_W-1:0] sel);
    prof_t p;
    case (sel)
      PROF_AMPLIFIED: p = '{scale: 32'd34359738, lac: 18'd144179, pers: 16'd29491,
                            oct: 3'd6, top: 7'd5, span: 7'd80};
      PROF_FLAT:      p = '{scale: 32'd64424509, lac: 18'd117965, pers: 16'd42598,
                            oct: 3'd2, top: 7'd45, span: 7'd15};
      default:        p = '{scale: 32'd42949673, lac: 18'd131072, pers: 16'd32768,
                            oct: 3'd4, top: 7'd20, span: 7'd50};
    endcase
    return p;
  endfunction

  // Seeded LCG shuffle of 0..255, keeping bit 0 of each entry (elaboration only)
  function automatic logic [GRAD_DEPTH-1:0] make_sign_table();
    logic [7:0]            perm [GRAD_DEPTH];
    logic [31:0]           r;
    logic [8:0]            j;
    logic [8:0]            m;
    logic [7:0]            tmp;
    logic [GRAD_DEPTH-1:0] res;
    for (int i = 0; i < GRAD_DEPTH; i++) begin
      perm[i] = 8'(i);
    end
    r = LCG_SEED;
    for (int i = GRAD_DEPTH - 1; i > 0; i--) begin
      r = r * LCG_MUL + LCG_INC;
      j = {1'b0, r[7:0]};
      m = 9'(i + 1);
      // reduce modulo i+1 by repeated subtraction
      for (int k = 0; k < GRAD_DEPTH / 2; k++) begin
        if (j >= m) begin
          j = j - m;
        end
      end
      tmp            = perm[i];
      perm[i]        = perm[j[7:0]];
      perm[j[7:0]]   = tmp;
    end
    for (int i = 0; i < GRAD_DEPTH; i++) begin
      res[i] = perm[i][0];
    end
    return res;
  endfunction

  localparam logic [GRAD_DEPTH-1:0] GRAD_SIGNS = make_sign_table();

endpackage

// ===== rtl/fnhp_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module fnhp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/fnhp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module fnhp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fnhp_pkg::SUM_W-1:0]  dividend,
  input  logic [fnhp_pkg::TOT_W-1:0]  divisor,
  output logic                        done,
  output logic [fnhp_pkg::QUO_W-1:0]  quotient
);
  import fnhp_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] dsr_r, dsr_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;

  // Step: compare against the shifted divisor, subtract, shift in a quotient bit
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      rem_nxt  = dividend;
      dsr_nxt  = SUM_W'({divisor, {(QUO_W - 1){1'b0}}});
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (rem_r >= dsr_r) begin
          rem_nxt = rem_r - dsr_r;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        dsr_nxt = dsr_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule

// ===== rtl/fractal_noise_height_profile.sv =====
// Top level: surface row of a column from octave-summed 1D gradient noise.
//
// Use: present a signed column on in_column with in_valid; the block returns
// one surface row per column on out_surface_row with out_valid. A transfer
// takes place on a rising edge where valid is high and stall is low, on
// either channel. Configuration (profile, height) is written through
// cfg_we / cfg_index / cfg_wdata while the block is idle.
// Timing: one column is in work at a time, so a new column is taken only
// after the previous one has reached the output register. The time to a
// result is set by the octave pipeline (one octave issued per cycle, five
// stages to drain), the 17-step divider that normalises the sum, and five
// mapping steps.
// Reset: the gradient sign RAM is filled from a constant table in a pass over
// all 256 entries; in_stall stays high until the pass ends. Profile returns to
// normal and height to 480.
// Stall: the result sits in an output register; while out_stall holds it the
// block still takes the next column and works on it, and only waits at the
// very end if the previous row has not yet been taken.
module fractal_noise_height_profile #(
  parameter int MAX_OCTAVES = fnhp_pkg::MAX_OCTAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fnhp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fnhp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fnhp_pkg::COL_W-1:0] in_column,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fnhp_pkg::ROW_W-1:0]        out_surface_row
);
  import fnhp_pkg::*;

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [8:0] {
    ST_FILL  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_NOISE = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_SQ    = 9'b000010000,
    ST_BAND  = 9'b000100000,
    ST_SCALE = 9'b001000000,
    ST_RECIP = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [PROF_W-1:0]   profile_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [GRAD_AW-1:0]  fill_cnt_r, fill_cnt_nxt;

  prof_t            prof;
  logic [OCT_W-1:0] oct_eff;

  // Octave sequencer state
  logic signed [COL_W-1:0] column_r;
  logic [OCT_W-1:0]        iss_left_r, iss_left_nxt;
  logic [SCALE_W-1:0]      s_r, s_nxt;
  logic [AMP_W-1:0]        amp_r, amp_nxt;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Octave pipeline
  logic                      p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r, p5_vld_r;
  logic [GRAD_AW-1:0]        p1_cell_r;
  logic [XF_W-1:0]           p1_xf_r, p2_xf_r, p2_xf2_r;
  logic [AMP_W-1:0]          p1_amp_r, p2_amp_r, p3_amp_r, p4_amp_r;
  logic signed [NOISE_W-1:0] p3_a_r, p3_d_r, p4_noise_r;
  logic [FADE_W-1:0]         p3_u_r;
  logic signed [SUM_W-1:0]   p5_prod_r;

  // Mapping registers
  logic [QUO_W-1:0]  nmag_r;
  logic [BAND_W-1:0] band_r;
  logic [V_W-1:0]    v_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_valid_r;

  logic issue, pipe_busy, div_start, div_done, out_load, amplified;
  logic [QUO_W-1:0] div_quo;
  logic [SUM_W-1:0] sum_mag;
  logic             sgn_a, sgn_b;

  // Combinational datapath terms
  logic signed [COL_W+SCALE_W:0] coord_prod;
  logic [SCALE_W+LAC_W-1:0]      s_round;
  logic [AMP_W+PERS_W-1:0]       amp_round;
  logic [2*XF_W-1:0]             xf_sq;
  logic [LAC_W-1:0]              fade_k;
  logic [XF_W+LAC_W-1:0]         fade_prod;
  logic signed [NOISE_W-1:0]     grad_a, grad_b;
  logic signed [2*NOISE_W-1:0]   lerp_prod;
  logic signed [NOISE_W+1:0]     noise_full;
  logic signed [2*NOISE_W-1:0]   wprod;
  logic [2*QUO_W-1:0]            sq_prod;
  logic [QUO_W:0]                t2;
  logic [PCT_W+QUO_W-1:0]        span_prod;
  logic [BAND_W:0]               band_sum;
  logic [HEIGHT_W+BAND_W-1:0]    hb_prod;
  logic [V_W+RCP_W-1:0]          rcp_prod;
  logic [ROW_W-1:0]              row_lo, row_fin;
  logic signed [HEIGHT_W+1:0]    h_m1;

  assign prof = prof_get(profile_r);

  always_comb begin
    if (int'(prof.oct) < MAX_OCTAVES) begin
      oct_eff = OCT_W'(prof.oct);
    end else begin
      oct_eff = OCT_W'(MAX_OCTAVES);
    end
  end

  // Gradient sign store, filled once after reset
  fnhp_ram #(
    .WIDTH (1),
    .DEPTH (GRAD_DEPTH)
  ) u_sign_ram (
    .clk     (clk),
    .we      (state_r == ST_FILL),
    .waddr   (fill_cnt_r),
    .wdata   (GRAD_SIGNS[fill_cnt_r]),
    .raddr_a (p1_cell_r),
    .raddr_b (p1_cell_r + GRAD_AW'(1)),
    .rdata_a (sgn_a),
    .rdata_b (sgn_b)
  );

  // Normalising divider, sum magnitude over total weight
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  fnhp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Handshake and control
  assign in_stall  = (state_r != ST_IDLE);
  assign issue     = (state_r == ST_NOISE) && (iss_left_r != '0);
  assign pipe_busy = p1_vld_r || p2_vld_r || p3_vld_r || p4_vld_r || p5_vld_r;
  assign div_start = (state_r == ST_NOISE) && (iss_left_r == '0) && !pipe_busy;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign amplified = (profile_r == PROF_AMPLIFIED);

  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    case (state_r)
      ST_FILL: begin
        fill_cnt_nxt = fill_cnt_r + GRAD_AW'(1);
        if (fill_cnt_r == GRAD_AW'(GRAD_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_NOISE;
        end
      end
      ST_NOISE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:    state_nxt = ST_BAND;
      ST_BAND:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_FILL;
    endcase
  end

  // Octave sequencer: scale and weight recurrences, one octave per cycle
  assign coord_prod = column_r * $signed({1'b0, s_r});
  assign s_round    = s_r * prof.lac + (SCALE_W + LAC_W)'(HALF_Q16);
  assign amp_round  = amp_r * prof.pers + (AMP_W + PERS_W)'(HALF_Q16);

  always_comb begin
    iss_left_nxt = iss_left_r;
    s_nxt        = s_r;
    amp_nxt      = amp_r;
    total_nxt    = total_r;
    sum_nxt      = sum_r;
    if (state_r == ST_IDLE) begin
      iss_left_nxt = oct_eff;
      s_nxt        = prof.scale;
      amp_nxt      = ONE_Q16;
      total_nxt    = '0;
      sum_nxt      = '0;
    end else begin
      if (issue) begin
        iss_left_nxt = iss_left_r - OCT_W'(1);
        s_nxt        = s_round[SCALE_W+15:16];
        amp_nxt      = amp_round[AMP_W+15:16];
        total_nxt    = total_r + TOT_W'(amp_r);
      end
      if (p5_vld_r) begin
        sum_nxt = sum_r + p5_prod_r;
      end
    end
  end

  // Pipeline arithmetic
  assign xf_sq     = p1_xf_r * p1_xf_r;
  assign fade_k    = LAC_W'(3 * 65536) - {1'b0, p2_xf_r, 1'b0};
  assign fade_prod = p2_xf2_r * fade_k;
  assign grad_a    = sgn_a ? $signed({2'b0, p2_xf_r}) : -$signed({2'b0, p2_xf_r});
  assign grad_b    = sgn_b ? ($signed({2'b0, p2_xf_r}) - 18'sd65536)
                           : (18'sd65536 - $signed({2'b0, p2_xf_r}));
  assign lerp_prod  = $signed({1'b0, p3_u_r}) * p3_d_r;
  assign noise_full = {{2{p3_a_r[NOISE_W-1]}}, p3_a_r} + lerp_prod[2*NOISE_W-1:16];
  assign wprod      = p4_noise_r * $signed({1'b0, p4_amp_r});

  // Mapping arithmetic
  assign sq_prod = div_quo * div_quo;

  always_comb begin
    if (sum_r[SUM_W-1]) begin
      t2 = (nmag_r > ONE_Q16) ? '0 : ((QUO_W + 1)'(ONE_Q16) - {1'b0, nmag_r});
    end else begin
      t2 = (nmag_r > ONE_Q16) ? {ONE_Q16, 1'b0} : ((QUO_W + 1)'(ONE_Q16) + {1'b0, nmag_r});
    end
  end

  assign span_prod = t2[QUO_W:1] * prof.span;
  assign band_sum  = (BAND_W + 1)'({prof.top, 16'b0}) + (BAND_W + 1)'(span_prod);
  assign hb_prod   = height_r * band_r;
  assign rcp_prod  = v_r * RECIP_100;

  // Clamp to 1..height-2 (height below 3 wraps as h-2)
  assign row_lo  = (row_r < ROW_W'(1)) ? ROW_W'(1) : row_r;
  assign h_m1    = $signed({2'b0, height_r}) - 14'sd1;
  assign row_fin = ($signed({2'b0, row_lo}) >= h_m1) ? (height_r - 12'd2) : row_lo;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_cnt_r  <= '0;
      profile_r   <= PROFILE_RST;
      height_r    <= HEIGHT_RST;
      iss_left_r  <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      p5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      iss_left_r <= iss_left_nxt;
      if (cfg_we && cfg_index == CFG_PROFILE) begin
        profile_r <= cfg_wdata[PROF_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_wdata[HEIGHT_W-1:0];
      end
      p1_vld_r <= issue;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      column_r <= in_column;
    end
    s_r     <= s_nxt;
    amp_r   <= amp_nxt;
    total_r <= total_nxt;
    sum_r   <= sum_nxt;

    // stage 1: cell index and fraction
    p1_cell_r <= coord_prod[GRAD_AW+31:32];
    p1_xf_r   <= coord_prod[31:16];
    p1_amp_r  <= amp_r;
    // stage 2: squared fraction, sign RAM read under way
    p2_xf_r   <= p1_xf_r;
    p2_xf2_r  <= xf_sq[2*XF_W-1:XF_W];
    p2_amp_r  <= p1_amp_r;
    // stage 3: fade and gradients
    p3_u_r    <= fade_prod[FADE_W+15:16];
    p3_a_r    <= grad_a;
    p3_d_r    <= grad_b - grad_a;
    p3_amp_r  <= p2_amp_r;
    // stage 4: interpolated noise
    p4_noise_r <= noise_full[NOISE_W-1:0];
    p4_amp_r   <= p3_amp_r;
    // stage 5: weighted term
    p5_prod_r  <= SUM_W'(wprod);

    // mapping steps
    if (state_r == ST_SQ) begin
      nmag_r <= amplified ? sq_prod[QUO_W+15:16] : div_quo;
    end
    if (state_r == ST_BAND) begin
      band_r <= band_sum[BAND_W-1:0];
    end
    if (state_r == ST_SCALE) begin
      v_r <= hb_prod[V_W+15:16];
    end
    if (state_r == ST_RECIP) begin
      row_r <= rcp_prod[RECIP_SHIFT+ROW_W-1:RECIP_SHIFT];
    end
    if (out_load) begin
      out_row_r <= row_fin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_surface_row = out_row_r;

  // Checks
  a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !pipe_busy && (iss_left_r == '0))
    else $error("divider started with octaves still in flight");

  a_pipe_in_noise: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_vld_r || p5_vld_r) |-> (state_r == ST_NOISE))
    else $error("octave pipeline active outside the noise phase");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (div_quo <= ONE_Q16))
    else $error("normalised noise magnitude above one");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && height_r >= 12'd3) |=>
      (out_surface_row >= ROW_W'(1)) && (out_surface_row <= height_r - 12'd2))
    else $error("surface row outside 1..height-2");

  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FILL) |=> (state_r != ST_FILL))
    else $error("sign table fill re-entered without reset");

endmodule

// ===== tb/sv/tb_fractal_noise_height_profile.sv =====
`timescale 1ns / 1ps
// Testbench for the fractal noise height profile: directed and random columns checked against a row predictor.
module tb_fractal_noise_height_profile;
  import fnhp_pkg::*;

  // Codes the package leaves unnamed: the spare profile and the unused register slots
  localparam logic [PROF_W-1:0]    PROF_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic signed [COL_W-1:0] COL_MAX = {1'b0, {(COL_W-1){1'b1}}};
  localparam logic signed [COL_W-1:0] COL_MIN = {1'b1, {(COL_W-1){1'b0}}};

  localparam int SETTLE_CYCLES = 40;    // longest column latency plus margin
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 112;

  typedef struct {
    longint scale, lac, pers, octaves, top, span;
  } terrain_t;

  typedef struct {
    logic signed [COL_W-1:0] column;
    logic [ROW_W-1:0]        row;
  } row_expect_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COL_W-1:0]   in_column;
  logic                      out_valid;
  logic                      out_stall;
  logic [ROW_W-1:0]          out_surface_row;

  // Predictor state: mirrors the block's registers and sign table
  logic [PROF_W-1:0]     cur_profile;
  logic [HEIGHT_W-1:0]   cur_height;
  logic [GRAD_DEPTH-1:0] sign_bits;

  row_expect_t pending_rows[$];
  int          mismatch_count;
  int          sender_idle_pct;
  int          recv_stall_pct;
  int          hold_request;
  int          hold_left;

  fractal_noise_height_profile uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_surface_row (out_surface_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Seed-42 LCG shuffle of 0..255, bit 0 of each entry kept
  function automatic logic [GRAD_DEPTH-1:0] build_sign_table();
    int               perm [GRAD_DEPTH];
    logic [31:0]      r;
    int               j;
    int               tmp;
    logic [GRAD_DEPTH-1:0] bits;
    for (int i = 0; i < GRAD_DEPTH; i++) perm[i] = i;
    r = LCG_SEED;
    for (int i = GRAD_DEPTH - 1; i > 0; i--) begin
      r = r * LCG_MUL + LCG_INC;
      j = int'(r[7:0]) % (i + 1);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < GRAD_DEPTH; i++) bits[i] = perm[i][0];
    return bits;
  endfunction

  // Scale, lacunarity, persistence, octaves and row band of each profile
  function automatic terrain_t terrain_of(input logic [PROF_W-1:0] sel);
    terrain_t t;
    case (sel)
      PROF_AMPLIFIED: t = '{34359738, 144179, 29491, 6, 5, 80};
      PROF_FLAT:      t = '{64424509, 117965, 42598, 2, 45, 15};
      default:        t = '{42949673, 131072, 32768, 4, 20, 50};
    endcase
    return t;
  endfunction

  // One octave of gradient noise, Q1.16 signed
  function automatic longint octave_noise(input longint col, input longint scale);
    longint     prod;
    longint     xf;
    longint     xf_sq;
    longint     fade;
    longint     ga;
    longint     gb;
    logic [7:0] grid_idx;
    logic [7:0] grid_next;
    prod = col * scale;
    grid_idx = prod[39:32];
    grid_next = grid_idx + 8'd1;
    xf = longint'(prod[31:16]);
    xf_sq = (xf * xf) >>> 16;
    fade = (xf_sq * (3 * 65536 - 2 * xf)) >>> 16;
    ga = sign_bits[grid_idx] ? xf : -xf;
    gb = sign_bits[grid_next] ? (xf - 65536) : (65536 - xf);
    return ga + ((fade * (gb - ga)) >>> 16);
  endfunction

  // Expected surface row for a column under the current profile and height
  function automatic logic [ROW_W-1:0] predict_surface_row(input logic signed [COL_W-1:0] column);
    terrain_t tp;
    longint   col;
    longint   s;
    longint   amp;
    longint   total;
    longint   acc;
    longint   n;
    longint   mag;
    longint   t;
    longint   h;
    longint   row;
    longint   octs;
    tp = terrain_of(cur_profile);
    col = longint'(column);
    octs = (tp.octaves < MAX_OCTAVES_DEF) ? tp.octaves : MAX_OCTAVES_DEF;
    s = tp.scale;
    amp = 65536;
    total = 0;
    acc = 0;
    for (int i = 0; i < octs; i++) begin
      acc += octave_noise(col, s) * amp;
      total += amp;
      amp = (amp * tp.pers + 32768) >>> 16;
      s = (s * tp.lac + 32768) >>> 16;
    end
    n = acc / total;
    // amplified: square the magnitude, keep the sign
    if (cur_profile == PROF_AMPLIFIED) begin
      mag = (n < 0) ? -n : n;
      mag = (mag * mag) >>> 16;
      n = (n < 0) ? -mag : mag;
    end
    t = n + 65536;
    if (t < 0) t = 0;
    if (t > 131072) t = 131072;
    t = t >>> 1;
    h = longint'(cur_height);
    row = (tp.top * h * 65536 + t * tp.span * h) / (100 * 65536);
    if (row < 1) row = 1;
    if (row >= h - 1) row = h - 2;
    return row[ROW_W-1:0];
  endfunction

  function automatic logic signed [COL_W-1:0] random_column();
    case ($urandom_range(9))
      0, 1:    return COL_W'($urandom_range(4000)) - COL_W'(2000);
      2:       return $urandom_range(1) ? COL_MAX - COL_W'($urandom_range(255))
                                        : COL_MIN + COL_W'($urandom_range(255));
      default: return COL_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one column, wait for its transfer, then queue the predicted row
  task automatic offer_column(input logic signed [COL_W-1:0] column);
    row_expect_t e;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid  <= 1'b0;
      in_column <= COL_W'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= column;
    do @(posedge clk); while (in_stall !== 1'b0);
    e.column = column;
    e.row    = predict_surface_row(column);
    pending_rows.push_back(e);
  endtask

  // Stop offering, let every pending row come out, then allow the pipeline to empty
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_rows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rows.size() != 0) begin
      flag_mismatch($sformatf("%0d surface rows never arrived", pending_rows.size()));
      pending_rows.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROFILE) cur_profile = data[PROF_W-1:0];
    else if (idx == CFG_HEIGHT) cur_height = data[HEIGHT_W-1:0];
  endtask

  // Profile write carries random upper bits, which the block must drop
  task automatic set_terrain(input logic [PROF_W-1:0] prof, input logic [HEIGHT_W-1:0] h);
    logic [CFG_DATA_W-1:0] data;
    settle();
    data = CFG_DATA_W'($urandom);
    data[PROF_W-1:0] = prof;
    write_reg(CFG_PROFILE, data);
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
  endtask

  // Reset values: normal profile, height 480, no register written
  task automatic test_reset_state();
    offer_column('0);
    offer_column(COL_W'(1));
    offer_column('1);
    offer_column(COL_MAX);
    offer_column(COL_MIN);
  endtask

  // Every profile code, the spare one falling back to normal
  task automatic test_profile_sweep();
    logic [PROF_W-1:0] profs [4];
    profs = '{PROF_NORMAL, PROF_AMPLIFIED, PROF_FLAT, PROF_SPARE};
    foreach (profs[k]) begin
      set_terrain(profs[k], HEIGHT_RST);
      offer_column(COL_MAX);
      offer_column(COL_MIN);
      offer_column(random_column());
    end
  endtask

  // Heights below three wrap the clamp; 3 and 4095 are the legal extremes
  task automatic test_height_edges();
    logic [HEIGHT_W-1:0] heights [5];
    heights = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4095};
    foreach (heights[k]) begin
      set_terrain(PROF_W'($urandom_range(3)), heights[k]);
      offer_column(random_column());
    end
  endtask

  // Writes to the unused register slots must change nothing
  task automatic test_unused_index();
    settle();
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    offer_column(random_column());
    offer_column(random_column());
  endtask

  // Long receiver hold-off while columns keep coming: the block must fill and stall its input
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    set_terrain(PROF_AMPLIFIED, 12'd4095);
    hold_request = HOLD_CYCLES;
    repeat (16) offer_column(random_column());
    settle();
  endtask

  // Random columns over a run of random settings and idling phases
  task automatic test_random_columns();
    logic [HEIGHT_W-1:0] h;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(7))
        0:       h = 12'd4095;
        1:       h = 12'd3;
        2:       h = HEIGHT_W'($urandom_range(2));
        default: h = HEIGHT_W'($urandom_range(4095, 3));
      endcase
      set_terrain(PROF_W'(seg % 4 == 3 ? $urandom_range(3) : seg % 3), h);
      case (seg % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      repeat (SEGMENT_ITEMS) offer_column(random_column());
    end
  endtask

  // Receiver stall: random per cycle, or a counted hold-off when one is asked for
  initial begin
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checking: each row transfer against the oldest pending prediction
  always @(posedge clk) begin
    row_expect_t head;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch($sformatf("surface row %0d with no column pending", out_surface_row));
      end else begin
        head = pending_rows.pop_front();
        if (out_surface_row !== head.row)
          flag_mismatch($sformatf("column %0d profile %0d height %0d: row %0d, want %0d",
                                  head.column, cur_profile, cur_height,
                                  out_surface_row, head.row));
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb_fractal_noise_height_profile: FAIL");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    sign_bits       = build_sign_table();
    cur_profile     = PROFILE_RST;
    cur_height      = HEIGHT_RST;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_column <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // sign table load pass after reset
    do @(posedge clk); while (in_stall !== 1'b0);

    test_reset_state();
    test_profile_sweep();
    test_height_edges();
    test_unused_index();
    test_backpressure();
    test_random_columns();

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    settle();
    if (mismatch_count == 0) begin
      $display("tb_fractal_noise_height_profile: PASS");
    end else begin
      $display("tb_fractal_noise_height_profile: FAIL");
    end
    $finish;
  end

endmodule
